[sv/tti_pkg.sv]
// Shared types, constants and the count table of the thermistor table interpolator.
`timescale 1ns / 1ps
package tti_pkg;

	localparam int ADC_W       = 16;
	localparam int TEMP_W      = 9;
	localparam int IDX_W       = 6;
	localparam int CNT_W       = 11;
	localparam int NUM_W       = 8;
	localparam int DEN_W       = 5;
	localparam int STEP_W      = 3;

	localparam logic [IDX_W-1:0]  LAST_IDX    = 6'd40;
	localparam logic [TEMP_W-1:0] BASE_TENTHS = 9'd100;
	localparam logic [TEMP_W-1:0] TOP_TENTHS  = 9'd500;

	// Request to the serial divider
	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	// Expected converter count at each whole degree from 10.0 up to 50.0
	function automatic logic [CNT_W-1:0] tti_count(input logic [IDX_W-1:0] i);
		logic [CNT_W-1:0] c;
		unique case (i)
			6'd0:  c = 11'd1487;
			6'd1:  c = 11'd1468;
			6'd2:  c = 11'd1448;
			6'd3:  c = 11'd1427;
			6'd4:  c = 11'd1407;
			6'd5:  c = 11'd1386;
			6'd6:  c = 11'd1365;
			6'd7:  c = 11'd1344;
			6'd8:  c = 11'd1323;
			6'd9:  c = 11'd1301;
			6'd10: c = 11'd1280;
			6'd11: c = 11'd1258;
			6'd12: c = 11'd1236;
			6'd13: c = 11'd1214;
			6'd14: c = 11'd1192;
			6'd15: c = 11'd1170;
			6'd16: c = 11'd1148;
			6'd17: c = 11'd1126;
			6'd18: c = 11'd1104;
			6'd19: c = 11'd1082;
			6'd20: c = 11'd1061;
			6'd21: c = 11'd1039;
			6'd22: c = 11'd1017;
			6'd23: c = 11'd996;
			6'd24: c = 11'd975;
			6'd25: c = 11'd953;
			6'd26: c = 11'd932;
			6'd27: c = 11'd912;
			6'd28: c = 11'd891;
			6'd29: c = 11'd871;
			6'd30: c = 11'd851;
			6'd31: c = 11'd831;
			6'd32: c = 11'd811;
			6'd33: c = 11'd792;
			6'd34: c = 11'd773;
			6'd35: c = 11'd754;
			6'd36: c = 11'd735;
			6'd37: c = 11'd717;
			6'd38: c = 11'd699;
			6'd39: c = 11'd682;
			6'd40: c = 11'd665;
			default: c = 11'd0;
		endcase
		return c;
	endfunction

endpackage

[sv/thermistor_table_interpolator.sv]
// Top level: converter count to temperature by table scan and interpolation.
//
//  channel   | dir | payload                          | accepted when
//  s_*       | in  | s_tdata[15:0]  adc_counts        | s_tvalid & s_tready
//  m_*       | out | m_tdata[8:0]   temperature_tenths| m_tvalid & m_tready
//
// The scan steps through the table one entry per cycle (up to 41 entries), then
// the serial divider interpolates when the count falls between two entries. The
// scan uses a single 16-bit compare and the divider yields one quotient bit per cycle.
// s_tready is high only in the idle state.
// A finished result waits in the output register; the next item may be taken
// meanwhile and its result holds until that register is free.
// Reset clears all control state; no table or memory needs a clearing pass.
`timescale 1ns / 1ps
module thermistor_table_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] adc_counts
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [8:0] temperature_tenths, [15:9] zero
);
	import tti_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DIV,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [ADC_W-1:0]   counts_q;
	logic [IDX_W-1:0]   idx_q;
	logic [TEMP_W-1:0]  base_q;
	logic [TEMP_W-1:0]  res_q;
	logic               m_tvalid_q;
	logic [TEMP_W-1:0]  m_tdata_q;

	logic [CNT_W-1:0]   tbl_cur;
	logic [CNT_W-1:0]   tbl_prev;
	logic               scan_go;
	logic [DEN_W-1:0]   diff;
	div_req_t           div_req;
	logic               div_done;
	logic [NUM_W-1:0]   div_quot;
	logic [TEMP_W-1:0]  base_nx;

	// Table reads at the current and the preceding entry
	assign tbl_cur  = tti_count(idx_q);
	assign tbl_prev = tti_count(IDX_W'(idx_q - 1'b1));

	// Keep scanning while the count is below the entry and the last entry is not reached
	assign scan_go = (idx_q != LAST_IDX) && (counts_q < {{(ADC_W-CNT_W){1'b0}}, tbl_cur});

	// Offset into the interval times ten, and the interval width
	assign diff          = DEN_W'(counts_q[CNT_W-1:0] - tbl_cur);
	assign div_req.num   = NUM_W'({diff, 3'b000}) + NUM_W'({diff, 1'b0});
	assign div_req.den   = DEN_W'(tbl_prev - tbl_cur);
	assign div_req.start = (state_q == S_SCAN) && !scan_go
	                       && (idx_q != '0) && (idx_q != LAST_IDX);

	assign base_nx = BASE_TENTHS + TEMP_W'({idx_q, 3'b000}) + TEMP_W'({idx_q, 1'b0});

	tti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			idx_q      <= '0;
		end else begin
			// Drop the taken item unless a new one replaces it
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						counts_q <= s_tdata;
						idx_q    <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_go) begin
						idx_q <= IDX_W'(idx_q + 1'b1);
					end else if (idx_q == '0) begin
						res_q   <= BASE_TENTHS;
						state_q <= S_DONE;
					end else if (idx_q == LAST_IDX) begin
						res_q   <= TOP_TENTHS;
						state_q <= S_DONE;
					end else begin
						base_q  <= base_nx;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						res_q   <= TEMP_W'(base_q - TEMP_W'(div_quot));
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= res_q;
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(16-TEMP_W){1'b0}}, m_tdata_q};

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider result outside divide state");
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> div_quot < NUM_W'(10))
		else $error("interpolation fraction out of range");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> idx_q <= LAST_IDX)
		else $error("scan index beyond table");
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (m_tdata_q >= BASE_TENTHS) && (m_tdata_q <= TOP_TENTHS))
		else $error("temperature out of range");

endmodule

[sv/tti_div.sv]
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tti_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tti_pkg::div_req_t         req,
	output logic                      done,
	output logic [tti_pkg::NUM_W-1:0] quot
);
	import tti_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W:0]    rem_sh;
	logic              ge;

	// Shift in the next numerator bit and trial-subtract
	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			// Flag completion on the last quotient bit
			done_q <= !req.start && busy_q && (step_q == STEP_W'(NUM_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				num_q  <= req.num;
				den_q  <= req.den;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q  <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
				num_q  <= {num_q[NUM_W-2:0], ge};
				step_q <= STEP_W'(step_q + 1'b1);
				if (step_q == STEP_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = num_q;

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without finishing");
	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> req.den != '0)
		else $error("divider started with zero divisor");

endmodule

[sim/tb_thermistor_table_interpolator.sv]
// Testbench for the thermistor table interpolator: random and edge-case counts, checked results.
`timescale 1ns / 1ps
module tb_thermistor_table_interpolator;
	import tti_pkg::*;

	localparam int unsigned STEP_TENTHS = 10;
	localparam int unsigned QUIET_TAIL  = 100;  // last items run with no idling
	localparam int unsigned DRAIN_CYCLES = 60;
	localparam int unsigned MAX_REPORTS = 10;

	// Calibration counts at each whole degree, 10.0 to 50.0
	localparam int unsigned CAL_COUNTS [41] = '{
		1487, 1468, 1448, 1427, 1407, 1386, 1365, 1344, 1323, 1301,
		1280, 1258, 1236, 1214, 1192, 1170, 1148, 1126, 1104, 1082,
		1061, 1039, 1017, 996, 975, 953, 932, 912, 891, 871,
		851, 831, 811, 792, 773, 754, 735, 717, 699, 682,
		665
	};

	typedef struct {
		logic [ADC_W-1:0]  counts;
		logic [TEMP_W-1:0] tenths;
	} reading_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;  // [15:0] adc_counts
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [8:0] temperature_tenths, [15:9] zero

	logic [ADC_W-1:0] pending_counts [$];
	reading_t         tenths_due [$];
	int unsigned      mismatches = 0;
	int unsigned      tx_gap = 0;
	int unsigned      rx_gap = 0;
	int unsigned      stall_odds = 0;  // percent chance of starting an idle burst
	int unsigned      cycle_count = 0;

	thermistor_table_interpolator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Scan the table, clamp at both ends, interpolate in between
	function automatic logic [TEMP_W-1:0] counts_to_tenths(input logic [ADC_W-1:0] counts);
		int unsigned k;
		int unsigned span;
		int unsigned frac;
		k = 0;
		while (k < LAST_IDX && counts < CAL_COUNTS[k])
			k++;
		if (k == 0)
			return BASE_TENTHS;
		if (k >= LAST_IDX)
			return TOP_TENTHS;
		span = CAL_COUNTS[k-1] - CAL_COUNTS[k];
		frac = (STEP_TENTHS * (counts - CAL_COUNTS[k])) / span;
		return TEMP_W'(BASE_TENTHS + STEP_TENTHS * k - frac);
	endfunction

	function automatic bit idling_allowed();
		return pending_counts.size() > QUIET_TAIL && $urandom_range(0, 99) < stall_odds;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Feed counts to the block; hold an item until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			tx_gap = 0;
		end else begin
			if (s_tvalid && s_tready)
				tenths_due.push_back('{s_tdata, counts_to_tenths(s_tdata)});
			if (s_tvalid && !s_tready) begin
				s_tvalid <= 1'b1;
			end else if (tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_counts.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (idling_allowed()) begin
				tx_gap = $urandom_range(1, 4) - 1;
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= pending_counts.pop_front();
			end
		end
	end

	// Check each result against the oldest expectation; stall the output at random
	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_gap = 0;
		end else begin
			cycle_count++;
			if (cycle_count % 256 == 0)
				stall_odds = ($urandom_range(0, 2) == 0) ? 0 : 30;
			if (m_tvalid && m_tready) begin
				if (tenths_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result 0x%04h at %0t", m_tdata, $realtime);
				end else begin
					want = tenths_due.pop_front();
					if (m_tdata !== {7'd0, want.tenths}) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("counts %0d: expected %0d, got 0x%04h at %0t",
								want.counts, want.tenths, m_tdata, $realtime);
					end
				end
			end
			if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else if (idling_allowed()) begin
				rx_gap = $urandom_range(1, 4) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Build the stimulus, release reset, wait for the pipeline to drain
	initial begin
		logic [ADC_W-1:0] directed [$];
		int unsigned pick;
		directed = '{16'd0, 16'hFFFF, 16'd1487, 16'd1486, 16'd1488, 16'd1468, 16'd1467,
			16'd682, 16'd681, 16'd683, 16'd665, 16'd664, 16'd699, 16'd700,
			16'd1000, 16'd1301, 16'd2047, 16'd2048, 16'h5555, 16'hAAAA,
			16'h8000, 16'd1, 16'd1061, 16'd1060};
		foreach (directed[i])
			pending_counts.push_back(directed[i]);
		repeat (950) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				pending_counts.push_back(ADC_W'($urandom_range(640, 1510)));
			else if (pick < 85)
				pending_counts.push_back(ADC_W'($urandom_range(0, 2047)));
			else
				pending_counts.push_back(ADC_W'($urandom));
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_counts.size() > 0 || s_tvalid || tenths_due.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && tenths_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
